FILE: rtl/cgla_pkg.sv
package cgla_pkg;

   localparam int FUNC_W  = 2;
   localparam int KEY_W   = 64;
   localparam int LANE_W  = 6;
   localparam int MASK_W  = 64;
   localparam int COUNT_W = 7;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_HEAD  = 2'd0,
      FUNC_EXTRA = 2'd1,
      FUNC_CLEAR = 2'd2
   } func_type;

   localparam logic KIND_ROW  = 1'b0;
   localparam logic KIND_EDGE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HEAD_SCAN,
      ST_XP_SCAN,
      ST_EMIT_START,
      ST_EMIT_SCAN,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic done;
      logic found;
   } scan_stat_type;

endpackage

FILE: rtl/cgla_if.sv
interface cgla_req_if;
   import cgla_pkg::*;

   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [KEY_W-1:0]  commit_key;
   logic [KEY_W-1:0]  parent_key;
   logic              has_parent;
   logic              last;

   modport source (output valid, func, commit_key, parent_key, has_parent, last,
                   input ready);
   modport sink (input valid, func, commit_key, parent_key, has_parent, last,
                 output ready);
endinterface

interface cgla_rsp_if;
   import cgla_pkg::*;

   logic               valid;
   logic               ready;
   logic               kind;
   logic [LANE_W-1:0]  commit_lane;
   logic               was_expected;
   logic [LANE_W-1:0]  target_lane;
   logic [MASK_W-1:0]  pass_mask;
   logic [COUNT_W-1:0] lane_count;
   logic               overflow;
   logic               last_result;

   modport source (output valid, kind, commit_lane, was_expected, target_lane,
                   pass_mask, lane_count, overflow, last_result,
                   input ready);
   modport sink (input valid, kind, commit_lane, was_expected, target_lane,
                 pass_mask, lane_count, overflow, last_result,
                 output ready);
endinterface

FILE: rtl/commit_graph_lane_allocator_top.sv
// A key lookup walks the lane table one lane per cycle through the key memory port,
// so a head or extra-parent item holds the block for one such lookup, and other items need none.
// On the last item of a commit, each buffered parent adds one lookup, then one row beat
// and one beat per edge follow, one per cycle while the response side is ready.
// One item is in work at a time. Synchronous reset clears all lanes, counters and
// flags at once; the key memory needs no clearing since only busy lanes are read.
module commit_graph_lane_allocator_top #(
   parameter int LANES       = 64,
   parameter int MAX_PARENTS = 8,
   parameter int KEY_BITS    = 64
) (
   input logic        clock,
   input logic        reset,
   cgla_req_if.sink   req_bus,
   cgla_rsp_if.source rsp_bus
);
   import cgla_pkg::*;

   localparam int LW  = $clog2(LANES);
   localparam int MW  = $clog2(LANES + 1);
   localparam int CW  = $clog2(MAX_PARENTS + 1);
   localparam int PIW = (MAX_PARENTS > 1) ? $clog2(MAX_PARENTS) : 1;

   state_type           state_ff, state_in;
   logic [LANES-1:0]    busy_ff, busy_in;
   logic [MW-1:0]       maxl_ff, maxl_in;
   logic [LW-1:0]       cur_lane_ff, cur_lane_in;
   logic                cur_exp_ff, cur_exp_in;
   logic                cur_valid_ff, cur_valid_in;
   logic                ovf_ff, ovf_in;
   logic [CW-1:0]       pcount_ff, pcount_in;
   logic [CW-1:0]       pidx_ff, pidx_in;
   logic [CW-1:0]       tcnt_ff, tcnt_in;
   logic [CW-1:0]       ecnt_ff, ecnt_in;
   logic [KEY_BITS-1:0] pkey_ff, pkey_in;
   logic                hasp_ff, hasp_in;
   logic                last_ff, last_in;
   logic [KEY_BITS-1:0] pbuf_ff [MAX_PARENTS];
   logic [LW-1:0]       tgt_ff [MAX_PARENTS];

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_kind_ff, rsp_kind_in;
   logic [LANE_W-1:0]   rsp_lane_ff, rsp_lane_in;
   logic                rsp_exp_ff, rsp_exp_in;
   logic [LANE_W-1:0]   rsp_tgt_ff, rsp_tgt_in;
   logic [MASK_W-1:0]   rsp_mask_ff, rsp_mask_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic                rsp_ovf_ff, rsp_ovf_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                pbuf_we;
   logic [PIW-1:0]      pbuf_wa;
   logic                tgt_we;
   logic [PIW-1:0]      tgt_wa;

   logic                scan_start;
   logic [KEY_BITS-1:0] scan_key;
   scan_stat_type       scan_stat;
   logic [LW-1:0]       scan_lane;
   logic [LW-1:0]       ram_rd_addr;
   logic [KEY_BITS-1:0] ram_rd_data;
   logic                ram_we;
   logic [LW-1:0]       ram_wa;

   logic [LANES-1:0]    free_vec;
   logic [LANES-1:0]    free_low;
   logic                any_free;
   logic [LW-1:0]       free_lane;
   logic [LW-1:0]       sel_lane;
   logic [MW-1:0]       sel_next;
   logic [MW-1:0]       free_next;
   logic [LANES-1:0]    own_bit;
   logic                accept;

   cgla_ram #(
      .WIDTH (KEY_BITS),
      .DEPTH (LANES)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (pkey_ff),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   cgla_scan #(
      .LANES    (LANES),
      .KEY_BITS (KEY_BITS)
   ) u_scan (
      .clock   (clock),
      .reset   (reset),
      .start   (scan_start),
      .key     (scan_key),
      .busy    (busy_ff),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data),
      .stat    (scan_stat),
      .lane    (scan_lane)
   );

   assign accept = req_bus.valid && (state_ff == ST_IDLE);

   always_comb begin
      free_vec  = ~busy_ff;
      free_low  = free_vec & (~free_vec + LANES'(1));
      any_free  = |free_vec;
      free_lane = '0;
      for (int i = 0; i < LANES; i++) begin
         if (free_low[i]) begin
            free_lane = free_lane | LW'(i);
         end
      end
      sel_lane  = scan_stat.found ? scan_lane : free_lane;
      sel_next  = MW'(sel_lane) + MW'(1);
      free_next = MW'(free_lane) + MW'(1);
      own_bit   = cur_valid_ff ? (LANES'(1) << cur_lane_ff) : '0;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_bus.func == FUNC_HEAD) begin
                  state_in = ST_HEAD_SCAN;
               end else if (req_bus.func == FUNC_EXTRA) begin
                  if (req_bus.has_parent) begin
                     state_in = ST_XP_SCAN;
                  end else if (req_bus.last) begin
                     state_in = ST_EMIT_START;
                  end
               end
            end
         end
         ST_HEAD_SCAN, ST_XP_SCAN: begin
            if (scan_stat.done) begin
               state_in = last_ff ? ST_EMIT_START : ST_IDLE;
            end
         end
         ST_EMIT_START: begin
            state_in = (pidx_ff < pcount_ff) ? ST_EMIT_SCAN : ST_OUT;
         end
         ST_EMIT_SCAN: begin
            if (scan_stat.done) begin
               state_in = ST_EMIT_START;
            end
         end
         ST_OUT: begin
            if (rsp_bus.ready && (ecnt_ff == tcnt_ff)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy_in      = busy_ff;
      maxl_in      = maxl_ff;
      cur_lane_in  = cur_lane_ff;
      cur_exp_in   = cur_exp_ff;
      cur_valid_in = cur_valid_ff;
      ovf_in       = ovf_ff;
      pcount_in    = pcount_ff;
      pidx_in      = pidx_ff;
      tcnt_in      = tcnt_ff;
      ecnt_in      = ecnt_ff;
      pkey_in      = pkey_ff;
      hasp_in      = hasp_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_lane_in  = rsp_lane_ff;
      rsp_exp_in   = rsp_exp_ff;
      rsp_tgt_in   = rsp_tgt_ff;
      rsp_mask_in  = rsp_mask_ff;
      rsp_count_in = rsp_count_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_last_in  = rsp_last_ff;
      pbuf_we      = 1'b0;
      pbuf_wa      = pcount_ff[PIW-1:0];
      tgt_we       = 1'b0;
      tgt_wa       = tcnt_ff[PIW-1:0];
      scan_start   = 1'b0;
      scan_key     = req_bus.commit_key[KEY_BITS-1:0];
      ram_we       = 1'b0;
      ram_wa       = free_lane;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pkey_in = req_bus.parent_key[KEY_BITS-1:0];
               hasp_in = req_bus.has_parent;
               last_in = req_bus.last;
               pidx_in = '0;
               tcnt_in = '0;
               if (req_bus.func == FUNC_CLEAR) begin
                  busy_in      = '0;
                  maxl_in      = '0;
                  cur_lane_in  = '0;
                  cur_exp_in   = 1'b0;
                  cur_valid_in = 1'b0;
                  pcount_in    = '0;
                  ovf_in       = 1'b0;
               end else if (req_bus.func == FUNC_HEAD) begin
                  pcount_in  = '0;
                  scan_start = 1'b1;
               end else if (req_bus.func == FUNC_EXTRA && req_bus.has_parent) begin
                  scan_start = 1'b1;
                  scan_key   = req_bus.parent_key[KEY_BITS-1:0];
               end
            end
         end
         ST_HEAD_SCAN: begin
            if (scan_stat.done) begin
               cur_exp_in = scan_stat.found;
               if (scan_stat.found || any_free) begin
                  cur_valid_in = 1'b1;
                  cur_lane_in  = sel_lane;
                  if (sel_next > maxl_ff) begin
                     maxl_in = sel_next;
                  end
                  ram_wa            = sel_lane;
                  ram_we            = hasp_ff;
                  busy_in[sel_lane] = hasp_ff;
               end else begin
                  ovf_in       = 1'b1;
                  cur_valid_in = 1'b0;
                  cur_lane_in  = '0;
               end
               if (hasp_ff && (pcount_ff < CW'(MAX_PARENTS))) begin
                  pbuf_we   = 1'b1;
                  pcount_in = pcount_ff + CW'(1);
               end
            end
         end
         ST_XP_SCAN: begin
            if (scan_stat.done) begin
               if (!scan_stat.found) begin
                  if (any_free) begin
                     ram_we             = 1'b1;
                     busy_in[free_lane] = 1'b1;
                     if (free_next > maxl_ff) begin
                        maxl_in = free_next;
                     end
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
               if (pcount_ff < CW'(MAX_PARENTS)) begin
                  pbuf_we   = 1'b1;
                  pcount_in = pcount_ff + CW'(1);
               end
            end
         end
         ST_EMIT_START: begin
            if (pidx_ff < pcount_ff) begin
               scan_start = 1'b1;
               scan_key   = pbuf_ff[pidx_ff[PIW-1:0]];
            end else begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_ROW;
               rsp_lane_in  = LANE_W'(cur_lane_ff);
               rsp_exp_in   = cur_exp_ff;
               rsp_tgt_in   = '0;
               rsp_mask_in  = MASK_W'(busy_ff & ~own_bit);
               rsp_count_in = COUNT_W'(maxl_ff);
               rsp_ovf_in   = ovf_ff;
               rsp_last_in  = (tcnt_ff == '0);
               ecnt_in      = '0;
               pcount_in    = '0;
            end
         end
         ST_EMIT_SCAN: begin
            if (scan_stat.done) begin
               pidx_in = pidx_ff + CW'(1);
               if (scan_stat.found) begin
                  tgt_we  = 1'b1;
                  tcnt_in = tcnt_ff + CW'(1);
               end
            end
         end
         ST_OUT: begin
            if (rsp_bus.ready) begin
               if (ecnt_ff < tcnt_ff) begin
                  rsp_kind_in = KIND_EDGE;
                  rsp_tgt_in  = LANE_W'(tgt_ff[ecnt_ff[PIW-1:0]]);
                  rsp_mask_in = '0;
                  rsp_last_in = ((ecnt_ff + CW'(1)) == tcnt_ff);
                  ecnt_in     = ecnt_ff + CW'(1);
               end else begin
                  rsp_valid_in = 1'b0;
               end
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_ff      <= '0;
         maxl_ff      <= '0;
         cur_lane_ff  <= '0;
         cur_exp_ff   <= 1'b0;
         cur_valid_ff <= 1'b0;
         ovf_ff       <= 1'b0;
         pcount_ff    <= '0;
         pidx_ff      <= '0;
         tcnt_ff      <= '0;
         ecnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         maxl_ff      <= maxl_in;
         cur_lane_ff  <= cur_lane_in;
         cur_exp_ff   <= cur_exp_in;
         cur_valid_ff <= cur_valid_in;
         ovf_ff       <= ovf_in;
         pcount_ff    <= pcount_in;
         pidx_ff      <= pidx_in;
         tcnt_ff      <= tcnt_in;
         ecnt_ff      <= ecnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pkey_ff      <= pkey_in;
      hasp_ff      <= hasp_in;
      last_ff      <= last_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_lane_ff  <= rsp_lane_in;
      rsp_exp_ff   <= rsp_exp_in;
      rsp_tgt_ff   <= rsp_tgt_in;
      rsp_mask_ff  <= rsp_mask_in;
      rsp_count_ff <= rsp_count_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      rsp_last_ff  <= rsp_last_in;
      if (pbuf_we) begin
         pbuf_ff[pbuf_wa] <= pkey_ff;
      end
      if (tgt_we) begin
         tgt_ff[tgt_wa] <= scan_lane;
      end
   end

   assign req_bus.ready        = (state_ff == ST_IDLE);
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.kind         = rsp_kind_ff;
   assign rsp_bus.commit_lane  = rsp_lane_ff;
   assign rsp_bus.was_expected = rsp_exp_ff;
   assign rsp_bus.target_lane  = rsp_tgt_ff;
   assign rsp_bus.pass_mask    = rsp_mask_ff;
   assign rsp_bus.lane_count   = rsp_count_ff;
   assign rsp_bus.overflow     = rsp_ovf_ff;
   assign rsp_bus.last_result  = rsp_last_ff;

endmodule

FILE: rtl/cgla_ram.sv
module cgla_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/cgla_scan.sv
module cgla_scan #(
   parameter int LANES    = 64,
   parameter int KEY_BITS = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [KEY_BITS-1:0]        key,
   input  logic [LANES-1:0]           busy,
   output logic [$clog2(LANES)-1:0]   rd_addr,
   input  logic [KEY_BITS-1:0]        rd_data,
   output cgla_pkg::scan_stat_type    stat,
   output logic [$clog2(LANES)-1:0]   lane
);
   import cgla_pkg::*;

   localparam int LW = $clog2(LANES);
   localparam logic [LW-1:0] LAST_LANE = LW'(LANES - 1);

   logic                running_ff, running_in;
   logic                chk_ff, chk_in;
   logic [LW-1:0]       addr_ff, addr_in;
   logic [LW-1:0]       chk_lane_ff, chk_lane_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   scan_stat_type       stat_ff, stat_in;
   logic [LW-1:0]       lane_ff, lane_in;
   logic                hit;
   logic                at_end;

   always_comb begin
      hit         = chk_ff && busy[chk_lane_ff] && (rd_data == key_ff);
      at_end      = chk_ff && (chk_lane_ff == LAST_LANE);
      running_in  = running_ff;
      chk_in      = chk_ff;
      addr_in     = addr_ff;
      chk_lane_in = chk_lane_ff;
      key_in      = key_ff;
      lane_in     = lane_ff;
      stat_in     = '0;
      if (start) begin
         running_in = 1'b1;
         chk_in     = 1'b0;
         addr_in    = '0;
         key_in     = key;
      end else if (running_ff) begin
         chk_in      = 1'b1;
         chk_lane_in = addr_ff;
         addr_in     = (addr_ff == LAST_LANE) ? addr_ff : addr_ff + LW'(1);
         if (hit || at_end) begin
            running_in    = 1'b0;
            chk_in        = 1'b0;
            stat_in.done  = 1'b1;
            stat_in.found = hit;
            lane_in       = chk_lane_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         chk_ff     <= 1'b0;
         stat_ff    <= '0;
      end else begin
         running_ff <= running_in;
         chk_ff     <= chk_in;
         stat_ff    <= stat_in;
      end
      addr_ff     <= addr_in;
      chk_lane_ff <= chk_lane_in;
      key_ff      <= key_in;
      lane_ff     <= lane_in;
   end

   assign rd_addr = addr_ff;
   assign stat    = stat_ff;
   assign lane    = lane_ff;

endmodule

FILE: rtl/cgla_checker.sv
module cgla_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       rsp_kind,
   input logic [cgla_pkg::LANE_W-1:0]  rsp_target_lane,
   input logic [cgla_pkg::MASK_W-1:0]  rsp_pass_mask,
   input logic [cgla_pkg::COUNT_W-1:0] rsp_lane_count,
   input logic                       rsp_last_result
);
   import cgla_pkg::*;

   // A new beat is never taken while a result is still being delivered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while a result is pending");

   // Once a result group has started, its remaining beats follow without a gap.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_result |=> rsp_valid && (rsp_kind == KIND_EDGE))
      else $error("result group broken before its last beat");

   // Edge beats carry no mask, and no lane can be busy before any lane was used.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_kind == KIND_EDGE) || (rsp_lane_count == '0)) |->
         (rsp_pass_mask == '0))
      else $error("pass mask set where no lane can pass");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
         $stable(rsp_target_lane) && $stable(rsp_pass_mask) && $stable(rsp_last_result))
      else $error("stalled result beat changed");

endmodule

bind commit_graph_lane_allocator_top cgla_checker u_cgla_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_kind        (rsp_bus.kind),
   .rsp_target_lane (rsp_bus.target_lane),
   .rsp_pass_mask   (rsp_bus.pass_mask),
   .rsp_lane_count  (rsp_bus.lane_count),
   .rsp_last_result (rsp_bus.last_result)
);
